### rtl/core/sgb_pkg.sv
package sgb_pkg;

    // defaults for the top-level parameters, and the largest image height
    localparam int DEF_MAX_RADIUS = 12;
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT     = 4096;

    // field and register widths
    localparam int PIXEL_W     = 32;
    localparam int RADIUS_W    = 4;
    localparam int IWIDTH_W    = 9;
    localparam int IHEIGHT_W   = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int ROW_W       = 13;
    localparam int OUT_ROW_W   = 12;

    // datapath widths
    localparam int LANES    = 4;
    localparam int CH_W     = 8;
    localparam int WEIGHT_W = 7;
    localparam int KSUM_W   = 10;
    localparam int ACC_W    = 18;
    localparam int TAP_W    = 5;
    localparam int DIST_W   = 4;
    localparam int MATH_W   = 16;

    // horizontal tap window, indexed by low column bits
    localparam int WIN_AW    = 5;
    localparam int WIN_DEPTH = 32;

    localparam logic [PIXEL_W-1:0] ALPHA_MASK = 32'hff000000;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RADIUS       = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2,
        REG_ALPHA_ONLY   = 2'd3
    } cfg_index_t;

    typedef logic [LANES-1:0][ACC_W-1:0] acc_vec_t;
    typedef logic [LANES-1:0][CH_W-1:0]  quo_vec_t;

    // kernel weight by distance from the center tap
    function automatic logic [WEIGHT_W-1:0] gauss_weight(input logic [DIST_W-1:0] d);
        logic [WEIGHT_W-1:0] w;
        unique case (d)
            4'd0:    w = 7'd80;
            4'd1:    w = 7'd77;
            4'd2:    w = 7'd70;
            4'd3:    w = 7'd59;
            4'd4:    w = 7'd46;
            4'd5:    w = 7'd34;
            4'd6:    w = 7'd24;
            4'd7:    w = 7'd15;
            4'd8:    w = 7'd9;
            4'd9:    w = 7'd5;
            4'd10:   w = 7'd2;
            4'd11:   w = 7'd1;
            default: w = 7'd0;
        endcase
        return w;
    endfunction

    // full kernel sum for a radius
    function automatic logic [KSUM_W-1:0] kernel_sum(input logic [RADIUS_W-1:0] r);
        logic [KSUM_W-1:0] s;
        unique case (r)
            4'd0:    s = 10'd80;
            4'd1:    s = 10'd234;
            4'd2:    s = 10'd374;
            4'd3:    s = 10'd492;
            4'd4:    s = 10'd584;
            4'd5:    s = 10'd652;
            4'd6:    s = 10'd700;
            4'd7:    s = 10'd730;
            4'd8:    s = 10'd748;
            4'd9:    s = 10'd758;
            4'd10:   s = 10'd762;
            default: s = 10'd764;
        endcase
        return s;
    endfunction

endpackage

### rtl/core/sgb_in_if.sv
interface sgb_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [sgb_pkg::PIXEL_W-1:0]   pixel;

    modport source (output valid, output opcode, output pixel, input ready);
    modport sink   (input valid, input opcode, input pixel, output ready);
endinterface

### rtl/core/sgb_out_if.sv
interface sgb_out_if;
    logic                          valid;
    logic                          ready;
    logic [sgb_pkg::PIXEL_W-1:0]   blurred_pixel;
    logic                          frame_last;

    modport source (output valid, output blurred_pixel, output frame_last, input ready);
    modport sink   (input valid, input blurred_pixel, input frame_last, output ready);
endinterface

### rtl/core/sgb_div.sv
module sgb_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  sgb_pkg::acc_vec_t             dividend,
    input  logic [sgb_pkg::KSUM_W-1:0]    divisor,
    output logic                          done,
    output sgb_pkg::quo_vec_t             quotient
);

    localparam int STEP_W = $clog2(sgb_pkg::CH_W);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    sgb_pkg::acc_vec_t           rem_reg, rem_next;
    sgb_pkg::quo_vec_t           quo_reg, quo_next;
    logic [sgb_pkg::KSUM_W-1:0]  dvs_reg, dvs_next;
    logic [sgb_pkg::ACC_W-1:0]   shifted;

    // one quotient bit per cycle in all four lanes
    always_comb
    begin
        shifted   = sgb_pkg::ACC_W'(dvs_reg) << step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(sgb_pkg::CH_W - 1);
            rem_next  = dividend;
            quo_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < sgb_pkg::LANES; i++)
            begin
                if (rem_reg[i] >= shifted)
                begin
                    rem_next[i]           = rem_reg[i] - shifted;
                    quo_next[i][step_reg] = 1'b1;
                end
            end
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/separable_gaussian_blur_argb.sv
// channel    dir    handshake          payload
// pixels     sink   valid/ready        opcode, pixel
// results    source valid/ready        blurred_pixel, frame_last
// config     sink   write_en           reg_index, write_data
//
// one item at a time: an accept, then for each horizontal result the taps, the
// divider start and the divider, then the position update and the emit test
// a pixel makes one horizontal result from column r on, up to r+1 at a row's end
// an emitted result adds row store reads at one per cycle, the divider and load
// reset clears the control state; the row store needs no clearing pass
// a stalled result waits in the output register while the next item is taken
module separable_gaussian_blur_argb #(
    parameter int MAX_RADIUS = sgb_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = sgb_pkg::DEF_MAX_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    sgb_in_if.sink                            pixels,
    sgb_out_if.source                         results,
    input  logic                              write_en,
    input  logic [sgb_pkg::CFG_INDEX_W-1:0]   reg_index,
    input  logic [sgb_pkg::CFG_DATA_W-1:0]    write_data
);

    localparam int SPAN     = 2 * MAX_RADIUS + 1;
    localparam int SW       = $clog2(SPAN);
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int RS_DEPTH = SPAN * MAX_WIDTH;
    localparam int RSW      = $clog2(RS_DEPTH);
    localparam int MW       = sgb_pkg::MATH_W;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_HTAP   = 11'b00000000010,
        ST_HSTART = 11'b00000000100,
        ST_HDIV   = 11'b00000001000,
        ST_ADV    = 11'b00000010000,
        ST_CHECK  = 11'b00000100000,
        ST_VTAP   = 11'b00001000000,
        ST_VDRAIN = 11'b00010000000,
        ST_VSTART = 11'b00100000000,
        ST_VDIV   = 11'b01000000000,
        ST_OUT    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [sgb_pkg::RADIUS_W-1:0]  radius_reg, radius_next;
    logic [sgb_pkg::IWIDTH_W-1:0]  image_width_reg, image_width_next;
    logic [sgb_pkg::IHEIGHT_W-1:0] image_height_reg, image_height_next;
    logic                          alpha_only_reg, alpha_only_next;

    // position counters
    logic [CW-1:0]                 in_col_reg, in_col_next;
    logic [sgb_pkg::ROW_W-1:0]     in_row_reg, in_row_next;
    logic [SW-1:0]                 in_slot_reg, in_slot_next;
    logic [CW-1:0]                 out_col_reg, out_col_next;
    logic [sgb_pkg::OUT_ROW_W-1:0] out_row_reg, out_row_next;
    logic [SW-1:0]                 out_slot_reg, out_slot_next;

    // sequencer
    logic [CW-1:0]                 k_reg, k_next;
    logic [CW-1:0]                 k_hi_reg, k_hi_next;
    logic                          rowend_reg, rowend_next;
    logic [sgb_pkg::TAP_W-1:0]     tap_reg, tap_next;
    logic [SW-1:0]                 vslot_reg, vslot_next;
    logic                          rd_pend_reg, rd_pend_next;
    logic                          rd_in_reg, rd_in_next;
    logic [sgb_pkg::WEIGHT_W-1:0]  rd_wt_reg, rd_wt_next;
    logic                          out_valid_reg, out_valid_next;

    // payload
    logic [sgb_pkg::PIXEL_W-1:0]   tap_window_reg [sgb_pkg::WIN_DEPTH];
    logic [sgb_pkg::PIXEL_W-1:0]   row_store_reg [RS_DEPTH];
    logic [sgb_pkg::PIXEL_W-1:0]   rd_data_reg;
    sgb_pkg::acc_vec_t             acc_reg, acc_next;
    logic [sgb_pkg::PIXEL_W-1:0]   out_pixel_reg;
    logic                          out_last_reg;

    // effective configuration
    logic [sgb_pkg::RADIUS_W-1:0]  eff_r;
    logic [WW-1:0]                 eff_w;
    logic [sgb_pkg::IHEIGHT_W-1:0] eff_h;
    logic [sgb_pkg::KSUM_W-1:0]    ksum;
    logic [MW-1:0]                 r16, w16, h16;

    always_comb
    begin
        eff_r = (radius_reg > sgb_pkg::RADIUS_W'(MAX_RADIUS))
              ? sgb_pkg::RADIUS_W'(MAX_RADIUS) : radius_reg;
        if (image_width_reg == '0)
            eff_w = WW'(1);
        else if (int'(image_width_reg) > MAX_WIDTH)
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(image_width_reg);
        if (image_height_reg == '0)
            eff_h = sgb_pkg::IHEIGHT_W'(1);
        else if (int'(image_height_reg) > sgb_pkg::MAX_HEIGHT)
            eff_h = sgb_pkg::IHEIGHT_W'(sgb_pkg::MAX_HEIGHT);
        else
            eff_h = image_height_reg;
        ksum = sgb_pkg::kernel_sum(eff_r);
        r16  = MW'(eff_r);
        w16  = MW'(eff_w);
        h16  = MW'(eff_h);
    end

    // accept decode
    logic          in_fire, take, ge_r, has_k, rowend;
    logic [MW-1:0] c16, k_lo16, k_hi16;

    assign pixels.ready = (state_reg == ST_IDLE);
    assign in_fire      = pixels.valid && pixels.ready;

    always_comb
    begin
        c16    = MW'(in_col_reg);
        take   = (pixels.opcode == sgb_pkg::OP_PIXEL) && (MW'(in_row_reg) < h16);
        rowend = (c16 + 1'b1) >= w16;
        ge_r   = c16 >= r16;
        has_k  = ge_r || rowend;
        k_lo16 = ge_r ? c16 - r16 : '0;
        k_hi16 = rowend ? w16 - 1'b1 : c16 - r16;
    end

    // tap distance and weight
    logic [MW-1:0]                t16;
    logic [sgb_pkg::DIST_W-1:0]   tap_dist;
    logic [sgb_pkg::WEIGHT_W-1:0] wt;
    logic                         last_tap;

    always_comb
    begin
        t16      = MW'(tap_reg);
        tap_dist = sgb_pkg::DIST_W'((t16 > r16) ? t16 - r16 : r16 - t16);
        wt       = sgb_pkg::gauss_weight(tap_dist);
        last_tap = (t16 == (r16 << 1));
    end

    // horizontal tap read from the window
    logic [MW-1:0]               colx16, col16;
    logic                        h_in;
    logic [sgb_pkg::PIXEL_W-1:0] win_rd;

    always_comb
    begin
        colx16 = MW'(k_reg) + t16;
        col16  = colx16 - r16;
        h_in   = (colx16 >= r16) && (col16 < w16);
        win_rd = tap_window_reg[col16[sgb_pkg::WIN_AW-1:0]];
    end

    // vertical tap row test
    logic [MW-1:0] yx16;
    logic          y_in;

    always_comb
    begin
        yx16 = MW'(out_row_reg) + t16;
        y_in = (yx16 >= r16) && ((yx16 - r16) < h16);
    end

    // row store addresses
    logic [RSW-1:0] wr_addr, rd_addr;
    assign wr_addr = RSW'(in_slot_reg) * RSW'(MAX_WIDTH) + RSW'(k_reg);
    assign rd_addr = RSW'(vslot_reg) * RSW'(MAX_WIDTH) + RSW'(out_col_reg);

    // shared divider
    logic               div_start, div_done;
    sgb_pkg::quo_vec_t  div_quo;
    logic [sgb_pkg::PIXEL_W-1:0] quo_word;

    assign div_start = (state_reg == ST_HSTART) || (state_reg == ST_VSTART);
    assign quo_word  = {div_quo[0], div_quo[1], div_quo[2], div_quo[3]};

    sgb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (ksum),
        .done     (div_done),
        .quotient (div_quo)
    );

    // multiply-accumulate, window taps or registered row store data
    logic                         mac_en, acc_clear;
    logic [sgb_pkg::PIXEL_W-1:0]  mac_pix;
    logic [sgb_pkg::WEIGHT_W-1:0] mac_wt;

    always_comb
    begin
        if (state_reg == ST_HTAP)
        begin
            mac_en  = h_in;
            mac_pix = win_rd;
            mac_wt  = wt;
        end
        else
        begin
            mac_en  = rd_pend_reg && rd_in_reg;
            mac_pix = rd_data_reg;
            mac_wt  = rd_wt_reg;
        end
        acc_next = acc_reg;
        if (acc_clear)
            acc_next = '0;
        else if (mac_en)
        begin
            for (int i = 0; i < sgb_pkg::LANES; i++)
            begin
                acc_next[i] = acc_reg[i] + sgb_pkg::ACC_W'(
                    mac_pix[sgb_pkg::CH_W*(sgb_pkg::LANES-1-i) +: sgb_pkg::CH_W])
                    * sgb_pkg::ACC_W'(mac_wt);
            end
        end
    end

    // emit test and output position
    logic [MW-1:0] or16, oc16, tr16, lastc16, s16, vstart16;
    logic          emit, out_free, frame_end;

    always_comb
    begin
        or16     = MW'(out_row_reg);
        oc16     = MW'(out_col_reg);
        tr16     = (or16 + r16 < h16 - 1'b1) ? or16 + r16 : h16 - 1'b1;
        lastc16  = (oc16 + r16 < w16 - 1'b1) ? oc16 + r16 : w16 - 1'b1;
        emit     = (or16 < h16) && ((MW'(in_row_reg) > tr16) ||
                   ((MW'(in_row_reg) == tr16) && (MW'(in_col_reg) > lastc16)));
        s16      = MW'(out_slot_reg);
        vstart16 = (s16 >= r16) ? s16 - r16 : s16 + MW'(SPAN) - r16;
        out_free = !out_valid_reg || results.ready;
        frame_end = (or16 == h16 - 1'b1) && (oc16 == w16 - 1'b1);
    end

    // sequencer next state
    always_comb
    begin
        state_next        = state_reg;
        radius_next       = radius_reg;
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        alpha_only_next   = alpha_only_reg;
        in_col_next       = in_col_reg;
        in_row_next       = in_row_reg;
        in_slot_next      = in_slot_reg;
        out_col_next      = out_col_reg;
        out_row_next      = out_row_reg;
        out_slot_next     = out_slot_reg;
        k_next            = k_reg;
        k_hi_next         = k_hi_reg;
        rowend_next       = rowend_reg;
        tap_next          = tap_reg;
        vslot_next        = vslot_reg;
        rd_pend_next      = 1'b0;
        rd_in_next        = y_in;
        rd_wt_next        = wt;
        acc_clear         = 1'b0;
        out_valid_next    = (out_valid_reg && !results.ready);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    k_next      = CW'(k_lo16);
                    k_hi_next   = CW'(k_hi16);
                    rowend_next = rowend;
                    tap_next    = '0;
                    acc_clear   = 1'b1;
                    if (take && has_k)
                        state_next = ST_HTAP;
                    else if (take)
                        state_next = ST_ADV;
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_HTAP:
            begin
                if (last_tap)
                    state_next = ST_HSTART;
                else
                    tap_next = tap_reg + 1'b1;
            end
            ST_HSTART:
            begin
                state_next = ST_HDIV;
            end
            ST_HDIV:
            begin
                if (div_done)
                begin
                    if (k_reg == k_hi_reg)
                        state_next = ST_ADV;
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        tap_next   = '0;
                        acc_clear  = 1'b1;
                        state_next = ST_HTAP;
                    end
                end
            end
            ST_ADV:
            begin
                if (rowend_reg)
                begin
                    in_col_next  = '0;
                    in_row_next  = in_row_reg + 1'b1;
                    in_slot_next = (in_slot_reg == SW'(SPAN - 1)) ? '0 : in_slot_reg + 1'b1;
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (emit)
                begin
                    tap_next   = '0;
                    vslot_next = SW'(vstart16);
                    acc_clear  = 1'b1;
                    state_next = ST_VTAP;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_VTAP:
            begin
                rd_pend_next = 1'b1;
                vslot_next   = (vslot_reg == SW'(SPAN - 1)) ? '0 : vslot_reg + 1'b1;
                if (last_tap)
                    state_next = ST_VDRAIN;
                else
                    tap_next = tap_reg + 1'b1;
            end
            ST_VDRAIN:
            begin
                state_next = ST_VSTART;
            end
            ST_VSTART:
            begin
                state_next = ST_VDIV;
            end
            ST_VDIV:
            begin
                if (div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (frame_end)
                    begin
                        in_col_next   = '0;
                        in_row_next   = '0;
                        in_slot_next  = '0;
                        out_col_next  = '0;
                        out_row_next  = '0;
                        out_slot_next = '0;
                    end
                    else if (oc16 == w16 - 1'b1)
                    begin
                        out_col_next  = '0;
                        out_row_next  = out_row_reg + 1'b1;
                        out_slot_next = (out_slot_reg == SW'(SPAN - 1))
                                      ? '0 : out_slot_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // register write ends the frame
        if (write_en)
        begin
            unique case (sgb_pkg::cfg_index_t'(reg_index))
                sgb_pkg::REG_RADIUS:
                    radius_next = write_data[sgb_pkg::RADIUS_W-1:0];
                sgb_pkg::REG_IMAGE_WIDTH:
                    image_width_next = write_data[sgb_pkg::IWIDTH_W-1:0];
                sgb_pkg::REG_IMAGE_HEIGHT:
                    image_height_next = write_data[sgb_pkg::IHEIGHT_W-1:0];
                sgb_pkg::REG_ALPHA_ONLY:
                    alpha_only_next = write_data[0];
            endcase
            in_col_next   = '0;
            in_row_next   = '0;
            in_slot_next  = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_slot_next = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            radius_reg       <= sgb_pkg::RADIUS_W'(12);
            image_width_reg  <= sgb_pkg::IWIDTH_W'(64);
            image_height_reg <= sgb_pkg::IHEIGHT_W'(64);
            alpha_only_reg   <= 1'b1;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            in_slot_reg      <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            out_slot_reg     <= '0;
            k_reg            <= '0;
            k_hi_reg         <= '0;
            rowend_reg       <= 1'b0;
            tap_reg          <= '0;
            vslot_reg        <= '0;
            rd_pend_reg      <= 1'b0;
            rd_in_reg        <= 1'b0;
            rd_wt_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            radius_reg       <= radius_next;
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            alpha_only_reg   <= alpha_only_next;
            in_col_reg       <= in_col_next;
            in_row_reg       <= in_row_next;
            in_slot_reg      <= in_slot_next;
            out_col_reg      <= out_col_next;
            out_row_reg      <= out_row_next;
            out_slot_reg     <= out_slot_next;
            k_reg            <= k_next;
            k_hi_reg         <= k_hi_next;
            rowend_reg       <= rowend_next;
            tap_reg          <= tap_next;
            vslot_reg        <= vslot_next;
            rd_pend_reg      <= rd_pend_next;
            rd_in_reg        <= rd_in_next;
            rd_wt_reg        <= rd_wt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // tap window write on a taken pixel
    always_ff @(posedge clk)
    begin
        if (in_fire && take)
            tap_window_reg[c16[sgb_pkg::WIN_AW-1:0]] <= pixels.pixel;
    end

    // row store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_HDIV) && div_done)
            row_store_reg[wr_addr] <= quo_word;
        rd_data_reg <= row_store_reg[rd_addr];
    end

    // accumulators and output register
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if ((state_reg == ST_OUT) && out_free)
        begin
            out_pixel_reg <= alpha_only_reg ? (quo_word & sgb_pkg::ALPHA_MASK) : quo_word;
            out_last_reg  <= frame_end;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.blurred_pixel = out_pixel_reg;
    assign results.frame_last    = out_last_reg;

endmodule

### rtl/core/sgb_checker.sv
module sgb_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [sgb_pkg::PIXEL_W-1:0] out_pixel,
    input logic                        out_last
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_pixel) && $stable(out_last)))
    else $error("stalled result changed");

    // one item at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after accept");

    // the block only goes busy by taking an item
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
    else $error("input ready dropped without an accept");

    // a result is never loaded in the cycle an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared right after accept");

endmodule

bind separable_gaussian_blur_argb sgb_checker u_sgb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixels.valid),
    .in_ready  (pixels.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_pixel (results.blurred_pixel),
    .out_last  (results.frame_last)
);
